/* sv/pbfc_pkg.sv */
// Package: shared widths, opcodes and helper functions for the bit map unit.
`default_nettype none
package pbfc_pkg;

  localparam int OPCODE_W   = 3;
  localparam int BIT_IDX_W  = 16;
  localparam int BYTE_IDX_W = 10;
  localparam int BYTE_W     = 8;
  localparam int FIELD_W    = 14;
  localparam int PCT_W      = 15;
  localparam int NB_W       = 12;
  localparam int PROD_W     = 29;
  localparam int PCT_SCALE  = 25600;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [PCT_W-1:0]    pct_t;
  typedef logic [NB_W-1:0]     nbytes_t;

  localparam opcode_t OP_TEST  = 3'd0;
  localparam opcode_t OP_SET   = 3'd1;
  localparam opcode_t OP_CLR   = 3'd2;
  localparam opcode_t OP_FILL1 = 3'd3;
  localparam opcode_t OP_FILL0 = 3'd4;
  localparam opcode_t OP_LOAD  = 3'd5;

  // bits of byte k that lie inside a field of n bits, MSB first
  function automatic logic [7:0] in_range_mask(input nbytes_t k, input field_t n);
    nbytes_t full;
    logic [7:0] m;
    full = {1'b0, n[FIELD_W-1:3]};
    if (k < full) begin
      m = 8'hFF;
    end else if (k == full) begin
      m = ~(8'hFF >> n[2:0]);
    end else begin
      m = 8'h00;
    end
    return m;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/pbfc_if.sv */
// Interfaces: command, result and configuration channels.
`default_nettype none
interface pbfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [pbfc_pkg::OPCODE_W-1:0]   opcode;
  logic [pbfc_pkg::BIT_IDX_W-1:0]  bit_index;
  logic [pbfc_pkg::BYTE_IDX_W-1:0] byte_index;
  logic [pbfc_pkg::BYTE_W-1:0]     byte_value;
  modport source (output valid, opcode, bit_index, byte_index, byte_value, input ready);
  modport sink (input valid, opcode, bit_index, byte_index, byte_value, output ready);
endinterface

interface pbfc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        bit_value;
  logic [pbfc_pkg::FIELD_W-1:0] set_count;
  logic [pbfc_pkg::PCT_W-1:0]   percent_q8;
  modport source (output valid, accepted, bit_value, set_count, percent_q8, input ready);
  modport sink (input valid, accepted, bit_value, set_count, percent_q8, output ready);
endinterface

interface pbfc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pbfc_pkg::FIELD_W-1:0] field_bits;
  modport source (output valid, field_bits, input ready);
  modport sink (input valid, field_bits, output ready);
endinterface
`default_nettype wire

/* sv/pbfc_store.sv */
// Byte store of the bit map with a zeroing sweep after reset.
`default_nettype none
module pbfc_store #(
  parameter int MAX_BYTES = 1024,
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata,
  output logic               busy
);

  localparam logic [AW-1:0] LastAddr = AW'(MAX_BYTES - 1);

  logic [7:0]    mem_r [MAX_BYTES];
  logic [7:0]    rdata_r;
  logic          busy_r;
  logic          busy_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    busy_nxt    = busy_r;
    clr_cnt_nxt = clr_cnt_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LastAddr) begin
        busy_nxt = 1'b0;
      end
    end
    wr_en   = busy_r ? 1'b1 : we;
    wr_addr = busy_r ? clr_cnt_r : waddr;
    wr_data = busy_r ? 8'h00 : wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(clr_cnt_r) == LastAddr)
    else $error("clear sweep ended early");

endmodule
`default_nettype wire

/* sv/pbfc_div.sv */
// Bit-serial restoring divider for the fill percentage.
`default_nettype none
module pbfc_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [pbfc_pkg::FIELD_W-1:0] count,
  input  wire logic [pbfc_pkg::FIELD_W-1:0] divisor,
  output logic                          done,
  output logic [pbfc_pkg::PCT_W-1:0]    quotient
);
  import pbfc_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_MUL  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  field_t            d_r, d_nxt;
  field_t            rem_r, rem_nxt;
  pct_t              q_r, q_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [FIELD_W:0]  trial;
  logic [FIELD_W:0]  diff;

  always_comb begin
    st_nxt   = st_r;
    prod_nxt = prod_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[PCT_W-1]};
    diff     = trial - {1'b0, d_r};
    case (st_r)
      DV_IDLE: begin
        if (start) begin
          prod_nxt = PROD_W'(count) * PROD_W'(PCT_SCALE);
          d_nxt    = divisor;
          st_nxt   = DV_MUL;
        end
      end
      DV_MUL: begin
        if (d_r == '0) begin
          q_nxt    = '0;
          done_nxt = 1'b1;
          st_nxt   = DV_IDLE;
        end else begin
          rem_nxt  = prod_r[PROD_W-1:PCT_W];
          q_nxt    = prod_r[PCT_W-1:0];
          step_nxt = '0;
          st_nxt   = DV_RUN;
        end
      end
      DV_RUN: begin
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = diff[FIELD_W-1:0];
          q_nxt   = {q_r[PCT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[FIELD_W-1:0];
          q_nxt   = {q_r[PCT_W-2:0], 1'b0};
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(PCT_W - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = DV_IDLE;
        end
      end
      default: begin
        st_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> q_r <= pct_t'(PCT_SCALE))
    else $error("percentage above full scale");

endmodule
`default_nettype wire

/* sv/piece_bitmap_with_fill_count_unit.sv */
// Top level: bit map command sequencer with running set-bit count.
// Test, set, clear, load byte: the result follows the divider, which skips its bit-serial run when the size is zero.
// Fill ones or zeros write ceil(size/8) store bytes, one store byte per cycle.
// The bit-serial divider runs for every transaction; a new one is taken only once the last result is pushed.
// After reset the store is zeroed byte by byte before commands are taken.
// Reset clears count, size and control state; config writes are taken at any time.
`default_nettype none
module piece_bitmap_with_fill_count_unit #(
  parameter int MAX_BYTES = 1024
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pbfc_in_if.sink   in_ch,
  pbfc_out_if.source out_ch,
  pbfc_cfg_if.sink  cfg_ch
);
  import pbfc_pkg::*;

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [31:0] TotalBits = 32'(MAX_BYTES) * 32'd8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0]            state_r, state_nxt;
  opcode_t               op_r, op_nxt;
  logic [BIT_IDX_W-1:0]  bit_idx_r, bit_idx_nxt;
  logic [BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [BYTE_W-1:0]     byte_val_r, byte_val_nxt;
  field_t                n_r, n_nxt;
  field_t                cnt_r, cnt_nxt;
  logic                  acc_r, acc_nxt;
  logic                  bv_r, bv_nxt;
  nbytes_t               fk_r, fk_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_bv_r, out_bv_nxt;
  field_t                out_cnt_r, out_cnt_nxt;
  pct_t                  out_pct_r, out_pct_nxt;

  logic          in_fire;
  logic          cfg_fire;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          clr_busy;
  logic          div_start;
  logic          div_done;
  pct_t          div_q;
  nbytes_t       nbytes;
  logic [7:0]    bit_mask;
  logic          bit_old;
  logic          bit_ok;
  logic [7:0]    load_mask;
  logic [3:0]    old_pop;
  logic [3:0]    new_pop;
  logic [FIELD_W:0] load_cnt;

  assign in_ch.ready  = (state_r == ST_IDLE) && !clr_busy;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign nbytes    = NB_W'(({1'b0, n_r} + 15'd7) >> 3);
  assign mem_raddr = (in_ch.opcode == OP_LOAD) ? AW'(in_ch.byte_index)
                                                : AW'(in_ch.bit_index[BIT_IDX_W-1:3]);
  assign bit_mask  = 8'h80 >> bit_idx_r[2:0];
  assign bit_old   = |(mem_rdata & bit_mask);
  assign bit_ok    = bit_idx_r < {2'b00, n_r};
  assign load_mask = in_range_mask(NB_W'(byte_idx_r), n_r);
  assign old_pop   = pop8(mem_rdata & load_mask);
  assign new_pop   = pop8(byte_val_r & load_mask);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bit_idx_nxt   = bit_idx_r;
    byte_idx_nxt  = byte_idx_r;
    byte_val_nxt  = byte_val_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    bv_nxt        = bv_r;
    fk_nxt        = fk_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_bv_nxt    = out_bv_r;
    out_cnt_nxt   = out_cnt_r;
    out_pct_nxt   = out_pct_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(bit_idx_r[BIT_IDX_W-1:3]);
    mem_wdata     = mem_rdata;
    div_start     = 1'b0;
    load_cnt      = '0;

    if (cfg_fire) begin
      if ({18'd0, cfg_ch.field_bits} > TotalBits) begin
        n_nxt = TotalBits[FIELD_W-1:0];
      end else begin
        n_nxt = cfg_ch.field_bits;
      end
      cnt_nxt = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_ch.opcode;
          bit_idx_nxt  = in_ch.bit_index;
          byte_idx_nxt = in_ch.byte_index;
          byte_val_nxt = in_ch.byte_value;
          acc_nxt      = 1'b0;
          bv_nxt       = 1'b0;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DIVS;
        case (op_r)
          OP_TEST, OP_SET, OP_CLR: begin
            if (bit_ok) begin
              acc_nxt = 1'b1;
              bv_nxt  = bit_old;
              if (op_r == OP_SET) begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | bit_mask;
                if (!bit_old && (cnt_r < n_r)) begin
                  cnt_nxt = cnt_r + field_t'(1);
                end
              end else if (op_r == OP_CLR) begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~bit_mask;
                if (bit_old && (cnt_r != '0)) begin
                  cnt_nxt = cnt_r - field_t'(1);
                end
              end
            end
          end
          OP_FILL1, OP_FILL0: begin
            acc_nxt = 1'b1;
            cnt_nxt = (op_r == OP_FILL1) ? n_r : '0;
            fk_nxt  = '0;
            if (nbytes != '0) begin
              state_nxt = ST_FILL;
            end
          end
          OP_LOAD: begin
            if ({2'b00, byte_idx_r} < nbytes) begin
              acc_nxt   = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = AW'(byte_idx_r);
              mem_wdata = byte_val_r;
              if ({1'b0, cnt_r} >= {11'd0, old_pop}) begin
                load_cnt = {1'b0, cnt_r} - {11'd0, old_pop};
              end
              load_cnt = load_cnt + {11'd0, new_pop};
              if (load_cnt > {1'b0, n_r}) begin
                cnt_nxt = n_r;
              end else begin
                cnt_nxt = load_cnt[FIELD_W-1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(fk_r);
        mem_wdata = (op_r == OP_FILL1) ? in_range_mask(fk_r, n_r) : 8'h00;
        fk_nxt    = fk_r + nbytes_t'(1);
        if (fk_nxt == nbytes) begin
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_bv_nxt    = bv_r;
          out_cnt_nxt   = cnt_r;
          out_pct_nxt   = div_q;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    bit_idx_r  <= bit_idx_nxt;
    byte_idx_r <= byte_idx_nxt;
    byte_val_r <= byte_val_nxt;
    acc_r      <= acc_nxt;
    bv_r       <= bv_nxt;
    fk_r       <= fk_nxt;
    out_acc_r  <= out_acc_nxt;
    out_bv_r   <= out_bv_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_pct_r  <= out_pct_nxt;
  end

  pbfc_store #(
    .MAX_BYTES (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (clr_busy)
  );

  pbfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .count    (cnt_r),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.bit_value  = out_bv_r;
  assign out_ch.set_count  = out_cnt_r;
  assign out_ch.percent_q8 = out_pct_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_r)
    else $error("set count above field size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted transaction not executed");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divider finished outside wait state");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for the bit map unit with a running set-bit count and fill percentage.
`default_nettype none
module tb_top;
  import pbfc_pkg::*;

  localparam int MAX_BYTES     = 1024;
  localparam int TOTAL_BITS    = MAX_BYTES * 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;
  localparam opcode_t OP_NOP6  = 3'd6;
  localparam opcode_t OP_NOP7  = 3'd7;

  typedef struct packed {
    logic   accepted;
    logic   bit_value;
    field_t set_count;
    pct_t   percent_q8;
  } bitmap_result_t;

  logic clk;
  logic rst_n;

  pbfc_in_if  in_if();
  pbfc_out_if out_if();
  pbfc_cfg_if cfg_if();

  piece_bitmap_with_fill_count_unit #(.MAX_BYTES(MAX_BYTES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow of the block state
  logic [7:0]  shadow_map [MAX_BYTES];
  int unsigned ones_cnt;
  field_t      field_cfg;

  bitmap_result_t pending_results[$];
  int unsigned    cmd_count;
  int unsigned    result_count;
  int unsigned    mismatch_count;
  int unsigned    cfg_writes;
  bit             tx_idle_en;
  bit             rx_idle_en;
  int unsigned    rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff_size();
    return (field_cfg > TOTAL_BITS) ? TOTAL_BITS : field_cfg;
  endfunction

  function automatic logic [7:0] byte_mask(input int unsigned k, input int unsigned n);
    if (n <= k * 8) return 8'h00;
    if (n - k * 8 >= 8) return 8'hFF;
    return 8'hFF << (8 - (n - k * 8));
  endfunction

  function automatic bitmap_result_t bitmap_apply(input opcode_t op,
                                                  input logic [BIT_IDX_W-1:0] bi,
                                                  input logic [BYTE_IDX_W-1:0] yi,
                                                  input logic [BYTE_W-1:0] yv);
    int unsigned n, nbytes, k, oldc, newc;
    logic [7:0] m;
    bitmap_result_t r;
    n = eff_size();
    nbytes = (n + 7) / 8;
    r = '0;
    case (op)
      OP_TEST, OP_SET, OP_CLR: begin
        if (bi < n) begin
          k = bi >> 3;
          m = 8'h80 >> bi[2:0];
          r.bit_value = |(shadow_map[k] & m);
          r.accepted = 1'b1;
          if (op == OP_SET) begin
            if (!r.bit_value && ones_cnt < n) ones_cnt++;
            shadow_map[k] = shadow_map[k] | m;
          end else if (op == OP_CLR) begin
            if (r.bit_value && ones_cnt > 0) ones_cnt--;
            shadow_map[k] = shadow_map[k] & ~m;
          end
        end
      end
      OP_FILL1: begin
        for (k = 0; k < nbytes; k++) shadow_map[k] = byte_mask(k, n);
        ones_cnt = n;
        r.accepted = 1'b1;
      end
      OP_FILL0: begin
        for (k = 0; k < nbytes; k++) shadow_map[k] = 8'h00;
        ones_cnt = 0;
        r.accepted = 1'b1;
      end
      OP_LOAD: begin
        if (yi < nbytes) begin
          m = byte_mask(yi, n);
          oldc = $countones(shadow_map[yi] & m);
          newc = $countones(yv & m);
          ones_cnt = (ones_cnt >= oldc) ? ones_cnt - oldc : 0;
          ones_cnt += newc;
          if (ones_cnt > n) ones_cnt = n;
          shadow_map[yi] = yv;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.set_count = field_t'(ones_cnt);
    if (n != 0 && ones_cnt != 0)
      r.percent_q8 = pct_t'((longint'(ones_cnt) * PCT_SCALE) / n);
    return r;
  endfunction

  // result receiver: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        wait_left = rx_hold;
        rx_hold = 0;
      end else if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        wait_left = rx_idle_en ? $urandom_range(0, 12) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_if.ready <= (wait_left == 0);
    end
  end

  always @(posedge clk) begin
    bitmap_result_t exp_r;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: acc=%0b bit=%0b count=%0d pct=%0d",
                   out_if.accepted, out_if.bit_value, out_if.set_count, out_if.percent_q8);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.accepted !== exp_r.accepted || out_if.bit_value !== exp_r.bit_value ||
            out_if.set_count !== exp_r.set_count || out_if.percent_q8 !== exp_r.percent_q8) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d: exp acc=%0b bit=%0b count=%0d pct=%0d, got acc=%0b bit=%0b count=%0d pct=%0d",
                     result_count, exp_r.accepted, exp_r.bit_value, exp_r.set_count,
                     exp_r.percent_q8, out_if.accepted, out_if.bit_value,
                     out_if.set_count, out_if.percent_q8);
        end
      end
    end
  end

  task automatic send_cmd(input opcode_t op, input logic [BIT_IDX_W-1:0] bi,
                          input logic [BYTE_IDX_W-1:0] yi, input logic [BYTE_W-1:0] yv);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.bit_index  <= bi;
    in_if.byte_index <= yi;
    in_if.byte_value <= yv;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_results.push_back(bitmap_apply(op, bi, yi, yv));
    cmd_count++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_field_bits(input field_t v);
    drain_results();
    cfg_if.valid      <= 1'b1;
    cfg_if.field_bits <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    field_cfg = v;
    ones_cnt = 0;
    cfg_writes++;
  endtask

  task automatic send_random_cmd();
    int unsigned sel, n, nbytes;
    opcode_t op;
    logic [BIT_IDX_W-1:0]  bi;
    logic [BYTE_IDX_W-1:0] yi;
    n = eff_size();
    nbytes = (n + 7) / 8;
    sel = $urandom_range(0, 99);
    bi = (sel % 8 == 0) ? BIT_IDX_W'($urandom) : BIT_IDX_W'($urandom_range(0, n + 2));
    yi = (sel % 8 == 1) ? BYTE_IDX_W'($urandom) : BYTE_IDX_W'($urandom_range(0, nbytes));
    if (sel < 60) op = opcode_t'($urandom_range(OP_TEST, OP_CLR));
    else if (sel < 64) op = opcode_t'($urandom_range(OP_FILL1, OP_FILL0));
    else if (sel < 96) op = OP_LOAD;
    else op = opcode_t'($urandom_range(OP_NOP6, OP_NOP7));
    send_cmd(op, bi, yi, BYTE_W'($urandom));
  endtask

  // size zero after reset: bit commands and loads are rejected
  task automatic test_empty_field();
    send_cmd(OP_TEST, '0, '0, '0);
    send_cmd(OP_SET, '0, '0, '0);
    send_cmd(OP_FILL1, '0, '0, '0);
    send_cmd(OP_LOAD, '0, '0, 8'hFF);
    send_cmd(OP_NOP6, '1, '1, '1);
  endtask

  task automatic test_partial_byte();
    write_field_bits(field_t'(13));
    send_cmd(OP_FILL1, '0, '0, '0);
    send_cmd(OP_TEST, 16'd12, '0, '0);
    send_cmd(OP_TEST, 16'd13, '0, '0);
    send_cmd(OP_SET, 16'hFFFF, '0, '0);
    send_cmd(OP_CLR, 16'd0, '0, '0);
    send_cmd(OP_CLR, 16'd0, '0, '0);
    send_cmd(OP_SET, 16'd0, '0, '0);
    send_cmd(OP_LOAD, '0, 10'd1, 8'hFF);
    send_cmd(OP_LOAD, '0, 10'h3FF, 8'h55);
    send_cmd(OP_LOAD, '0, 10'd2, 8'h55);
    send_cmd(OP_FILL0, '0, '0, '0);
    send_cmd(OP_NOP7, '0, '0, '0);
  endtask

  // count cleared by a size write while the map still holds ones
  task automatic test_count_floor();
    write_field_bits(field_t'(16));
    send_cmd(OP_FILL1, '0, '0, '0);
    write_field_bits(field_t'(8));
    send_cmd(OP_CLR, 16'd0, '0, '0);
    send_cmd(OP_LOAD, '0, 10'd0, 8'h0F);
  endtask

  task automatic test_oversized_field();
    write_field_bits('1);
    send_cmd(OP_FILL1, '0, '0, '0);
    send_cmd(OP_TEST, 16'd8191, '0, '0);
    send_cmd(OP_TEST, 16'd8192, '0, '0);
    send_cmd(OP_LOAD, '0, 10'd1023, 8'h00);
    send_cmd(OP_CLR, 16'd8190, '0, '0);
    write_field_bits(field_t'(TOTAL_BITS));
    send_cmd(OP_SET, 16'd8191, '0, '0);
    send_cmd(OP_FILL0, '0, '0, '0);
  endtask

  // receiver holds off while commands keep coming, then the sender waits for all results
  task automatic test_backpressure();
    write_field_bits(field_t'(100));
    send_cmd(OP_FILL1, '0, '0, '0);
    drain_results();
    tx_idle_en = 1'b0;
    rx_hold = 400;
    repeat (30) send_random_cmd();
    drain_results();
    tx_idle_en = 1'b1;
    repeat (10) send_random_cmd();
  endtask

  task automatic test_random_traffic();
    field_t sz;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 9))
        0: sz = '0;
        1: sz = '1;
        2: sz = field_t'($urandom);
        default: sz = field_t'($urandom_range(1, 200));
      endcase
      write_field_bits(sz);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0)
        send_cmd(($urandom_range(0, 1) != 0) ? OP_FILL1 : OP_FILL0, '0, '0, '0);
      repeat (110) send_random_cmd();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < MAX_BYTES; i++) shadow_map[i] = 8'h00;
    ones_cnt = 0;
    field_cfg = '0;
    cmd_count = 0;
    result_count = 0;
    mismatch_count = 0;
    cfg_writes = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold = 0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= OP_TEST;
    in_if.bit_index   <= '0;
    in_if.byte_index  <= '0;
    in_if.byte_value  <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.field_bits <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_field();
    test_partial_byte();
    test_count_floor();
    test_oversized_field();
    test_backpressure();
    test_random_traffic();
    drain_results();

    $display("Sent %0d commands, checked %0d results over %0d field size writes",
             cmd_count, result_count, cfg_writes);
    $display("Fields from empty through partial bytes to oversized; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
sv/pbfc_pkg.sv
sv/pbfc_if.sv
sv/pbfc_store.sv
sv/pbfc_div.sv
sv/piece_bitmap_with_fill_count_unit.sv
verif/tb_top.sv
